FILE: design/fds_pkg.sv
// Shared types, constants and helpers for the frame difference segmenter.
// Used by fds_store, frame_difference_segmenter and the testbench; depends on nothing else.
package fds_pkg;

  // Frame store geometry
  localparam int MAX_PIXELS = 131072;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int LEN_W      = ADDR_W + 1;

  // Configuration port
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS   = 2'd1;
  localparam logic [THR_W-1:0]     THR_RESET          = 8'd20;
  localparam int                   FRAME_PIXELS_RESET = 76800;

  // BT.601 gray weights in Q14, with rounding
  localparam int PB_W       = 19;
  localparam int PG_W       = 22;
  localparam int PR_W       = 21;
  localparam int SUM_W      = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [PB_W-1:0]  W_BLUE  = 19'd1868;
  localparam logic [PG_W-1:0]  W_GREEN = 22'd9617;
  localparam logic [PR_W-1:0]  W_RED   = 21'd4899;
  localparam logic [SUM_W-1:0] ROUND   = 22'd8192;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Background write from the decision stage
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    pix_t              data;
  } bg_wr_t;

  // Read and prior-frame write request from the accept stage
  typedef struct packed {
    logic              rd_en;
    logic              prior_we;
    logic [ADDR_W-1:0] addr;
  } store_req_t;

  // Clamp a frame size write into 1 .. MAX_PIXELS
  function automatic logic [LEN_W-1:0] frame_len(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > 32'(MAX_PIXELS)) begin
      w = 32'(MAX_PIXELS);
    end
    return LEN_W'(w);
  endfunction

endpackage

FILE: design/frame_difference_segmenter.sv
// Frame difference motion segmenter: top level, pipeline and configuration.
// Depends on fds_pkg and fds_store.
//
// Usage:
//   Pixels enter on the in_ channel (valid/ready) in raster order, BGR.
//   Each accepted pixel yields exactly one transaction on the out_ channel:
//   foreground colour (zero when static), background entry after update,
//   the moving flag and a frame_end flag on the last pixel of a frame.
//   cfg_we/cfg_index/cfg_wdata write diff_threshold (index 0) and
//   frame_pixels (index 1); write only while the block is idle.
//   Throughput: one pixel per cycle when not stalled. Stages from input
//   accept to out_valid: memory read, weighted products, sum and compare.
//   After reset the background store is swept to zero, one entry a cycle,
//   over all MAX_PIXELS (131072) entries; in_ready stays low meanwhile.
//   The first frame after reset only loads the prior-frame store.
//   A stalled receiver holds the output register; the stages behind it keep
//   filling until full, then in_ready drops.
module frame_difference_segmenter import fds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_pix_blue,
  input  logic [7:0]           in_pix_green,
  input  logic [7:0]           in_pix_red,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_fore_blue,
  output logic [7:0]           out_fore_green,
  output logic [7:0]           out_fore_red,
  output logic [7:0]           out_back_blue,
  output logic [7:0]           out_back_green,
  output logic [7:0]           out_back_red,
  output logic                 out_moving,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration and frame position
  logic [THR_W-1:0]  thr_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] pos_nxt;
  logic              primed_r;
  logic              last;

  // Handshake and stage enables
  logic en_out;
  logic en2;
  logic en1;
  logic accept;
  logic clearing;

  // Store interface
  store_req_t store_req;
  bg_wr_t     bg_wr;
  pix_t       cur_pix;
  pix_t       prior_rd;
  pix_t       bg_rd;

  // Stage 1: memory data arrives
  logic              v1_r;
  pix_t              pix1_r;
  logic [ADDR_W-1:0] pos1_r;
  logic              prim1_r;
  logic              last1_r;
  logic              fwd1_v_r;
  pix_t              fwd1_d_r;
  pix_t              bg1_eff;
  logic [7:0]        db;
  logic [7:0]        dg;
  logic [7:0]        dr;

  // Stage 2: products held, decision made
  logic              v2_r;
  pix_t              pix2_r;
  logic [ADDR_W-1:0] pos2_r;
  logic              prim2_r;
  logic              last2_r;
  pix_t              bg2_r;
  logic [PB_W-1:0]   pb2_r;
  logic [PG_W-1:0]   pg2_r;
  logic [PR_W-1:0]   pr2_r;
  logic [SUM_W-1:0]  sum2;
  logic [7:0]        gray2;
  logic              moving2;

  // Output register
  logic out_valid_r;
  pix_t fore_r;
  pix_t back_r;
  logic moving_r;
  logic fend_r;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Stage enables: a stage moves when empty or when the next one moves
  assign en_out   = !out_valid_r || out_ready;
  assign en2      = !v2_r || en_out;
  assign en1      = !v1_r || en2;
  assign in_ready = en1 && !clearing;
  assign accept   = in_valid && in_ready;

  assign cur_pix = '{red: in_pix_red, green: in_pix_green, blue: in_pix_blue};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      len_r <= frame_len(CFG_W'(FRAME_PIXELS_RESET));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIFF_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        REG_FRAME_PIXELS:   len_r <= frame_len(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Advance the pixel position, wrap at the frame length
  assign last    = ({1'b0, pos_r} + 1'b1) >= len_r;
  assign pos_nxt = last ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      primed_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      if (last) begin
        primed_r <= 1'b1;
      end
    end
  end

  assign store_req = '{rd_en: en1, prior_we: accept, addr: pos_r};

  fds_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (store_req),
    .prior_wdata (cur_pix),
    .bg_wr       (bg_wr),
    .prior_rdata (prior_rd),
    .bg_rdata    (bg_rd),
    .clearing    (clearing)
  );

  // Stage 1 logic: forward any background write missed by the read
  assign bg1_eff = fwd1_v_r ? fwd1_d_r : bg_rd;
  assign db      = abs_diff(pix1_r.blue,  prior_rd.blue);
  assign dg      = abs_diff(pix1_r.green, prior_rd.green);
  assign dr      = abs_diff(pix1_r.red,   prior_rd.red);

  // Stage 2 logic: sum, round, compare
  assign sum2    = SUM_W'(pb2_r) + SUM_W'(pg2_r) + SUM_W'(pr2_r) + ROUND;
  assign gray2   = sum2[SUM_W-1:GRAY_SHIFT];
  assign moving2 = prim2_r && (gray2 > thr_r);

  assign bg_wr.en   = en_out && v2_r && prim2_r && !moving2;
  assign bg_wr.addr = pos2_r;
  assign bg_wr.data = pix2_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= accept;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r   <= cur_pix;
      pos1_r   <= pos_r;
      prim1_r  <= primed_r;
      last1_r  <= last;
      fwd1_v_r <= bg_wr.en && (bg_wr.addr == pos_r);
      fwd1_d_r <= bg_wr.data;
    end
  end

  // Stage 2 payload: register the weighted products
  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      pix2_r  <= pix1_r;
      pos2_r  <= pos1_r;
      prim2_r <= prim1_r;
      last2_r <= last1_r;
      bg2_r   <= (bg_wr.en && (bg_wr.addr == pos1_r)) ? bg_wr.data : bg1_eff;
      pb2_r   <= PB_W'(db) * W_BLUE;
      pg2_r   <= PG_W'(dg) * W_GREEN;
      pr2_r   <= PR_W'(dr) * W_RED;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (en_out && v2_r) begin
      fore_r   <= moving2 ? pix2_r : '0;
      back_r   <= (prim2_r && !moving2) ? pix2_r : bg2_r;
      moving_r <= moving2;
      fend_r   <= last2_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fore_blue  = fore_r.blue;
  assign out_fore_green = fore_r.green;
  assign out_fore_red   = fore_r.red;
  assign out_back_blue  = back_r.blue;
  assign out_back_green = back_r.green;
  assign out_back_red   = back_r.red;
  assign out_moving     = moving_r;
  assign out_frame_end  = fend_r;

`ifndef NO_ASSERTIONS
  // No pixel may enter while the background sweep runs
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input accepted during background clear");

  // A static pixel carries no foreground colour
  a_static_fore_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_moving) |-> (fore_r == '0))
    else $error("static pixel with non-zero foreground");

  // Once the first frame is complete the block stays primed
  a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped");

  // Background is never written for a pixel of the first frame
  a_bg_write_primed: assert property (@(posedge clk) disable iff (!rst_n)
    bg_wr.en |-> (prim2_r && v2_r && !clearing))
    else $error("background write outside a primed pixel");
`endif

endmodule

FILE: design/fds_store.sv
// Prior-frame and background pixel memories with the post-reset clearing sweep.
// Depends on fds_pkg.
module fds_store import fds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  input  pix_t       prior_wdata,
  input  bg_wr_t     bg_wr,
  output pix_t       prior_rdata,
  output pix_t       bg_rdata,
  output logic       clearing
);

  pix_t              prior_mem [MAX_PIXELS];
  pix_t              bg_mem    [MAX_PIXELS];
  pix_t              prior_rd_r;
  pix_t              bg_rd_r;
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              bg_we;
  logic [ADDR_W-1:0] bg_waddr;
  pix_t              bg_wdata;

  // Sweep zeros through the background store once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(MAX_PIXELS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Select the background write source
  assign bg_we    = clearing_r | bg_wr.en;
  assign bg_waddr = clearing_r ? clr_addr_r : bg_wr.addr;
  assign bg_wdata = clearing_r ? '0 : bg_wr.data;

  // Prior frame: read old contents, write the new pixel at the same address
  always_ff @(posedge clk) begin
    if (req.prior_we) begin
      prior_mem[req.addr] <= prior_wdata;
    end
    if (req.rd_en) begin
      prior_rd_r <= prior_mem[req.addr];
    end
  end

  // Background: read-first, hazards are resolved by the caller
  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[bg_waddr] <= bg_wdata;
    end
    if (req.rd_en) begin
      bg_rd_r <= bg_mem[req.addr];
    end
  end

  assign prior_rdata = prior_rd_r;
  assign bg_rdata    = bg_rd_r;
  assign clearing    = clearing_r;

endmodule

FILE: tb/tb_frame_difference_segmenter.sv
`timescale 1ns / 100ps
// Self-checking bench for frame_difference_segmenter: BGR pixel streams against a
// motion predictor, with threshold and frame-size sweeps and back-pressure phases.
// Depends on fds_pkg and the segmenter RTL.
module tb_frame_difference_segmenter;
  import fds_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 13;

  // Positions 0..PRIMED_SPAN-1 are loaded before priming; later frames stay inside
  localparam int PRIMED_SPAN = 257;
  localparam int SCENE_DEPTH = 512;

  // BT.601 gray weights, Q14 with rounding
  localparam int GRAY_WB         = 1868;
  localparam int GRAY_WG         = 9617;
  localparam int GRAY_WR         = 4899;
  localparam int GRAY_HALF       = 8192;
  localparam int GRAY_FRAC_BITS  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = 2'd3;
  localparam logic [CFG_W-1:0]     FRAME_OVERSIZE = '1;

  typedef struct packed {
    pix_t fore;
    pix_t back;
    logic moving;
    logic frame_end;
  } seg_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_pix_blue = '0;
  logic [7:0]           in_pix_green = '0;
  logic [7:0]           in_pix_red = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_fore_blue;
  logic [7:0]           out_fore_green;
  logic [7:0]           out_fore_red;
  logic [7:0]           out_back_blue;
  logic [7:0]           out_back_green;
  logic [7:0]           out_back_red;
  logic                 out_moving;
  logic                 out_frame_end;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Pending pixels, expected segmentation results, pacing
  pix_t        pixels_to_send [$];
  seg_result_t expected_segments [$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          pace_send  [4] = '{0, 51, 0, 9};
  int          pace_stall [4] = '{0, 0, 51, 9};
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;
  int          error_count = 0;
  int unsigned offered_count = 0;
  int unsigned result_count = 0;

  // Predictor state
  pix_t             last_frame [MAX_PIXELS];
  pix_t             bg_model   [MAX_PIXELS];
  int unsigned      pix_pos = 0;
  bit               primed = 1'b0;
  logic [7:0]       thr_now = THR_RESET;
  logic [CFG_W-1:0] frame_cfg = CFG_W'(FRAME_PIXELS_RESET);

  // Stimulus-side copy of the scene, indexed by position
  pix_t        scene [SCENE_DEPTH];
  int unsigned gen_pos = 0;

  frame_difference_segmenter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pix_blue   (in_pix_blue),
    .in_pix_green  (in_pix_green),
    .in_pix_red    (in_pix_red),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fore_blue (out_fore_blue),
    .out_fore_green(out_fore_green),
    .out_fore_red  (out_fore_red),
    .out_back_blue (out_back_blue),
    .out_back_green(out_back_green),
    .out_back_red  (out_back_red),
    .out_moving    (out_moving),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Effective frame length: zero acts as one, oversize saturates
  function automatic int unsigned frame_span();
    int unsigned n;
    n = frame_cfg;
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_PIXELS) begin
      n = MAX_PIXELS;
    end
    return n;
  endfunction

  // Segment one pixel: compare with the prior frame, update the prior frame and, for a static pixel, the background
  function automatic seg_result_t segment_pixel(pix_t px);
    seg_result_t res;
    pix_t        old;
    int unsigned d_b, d_g, d_r, gray;
    res = '0;
    old = last_frame[pix_pos];
    res.frame_end = (pix_pos + 1 >= frame_span());
    if (primed) begin
      d_b  = (px.blue  > old.blue)  ? px.blue  - old.blue  : old.blue  - px.blue;
      d_g  = (px.green > old.green) ? px.green - old.green : old.green - px.green;
      d_r  = (px.red   > old.red)   ? px.red   - old.red   : old.red   - px.red;
      gray = (GRAY_WB * d_b + GRAY_WG * d_g + GRAY_WR * d_r + GRAY_HALF) >> GRAY_FRAC_BITS;
      if (gray > thr_now) begin
        res.moving = 1'b1;
        res.fore   = px;
      end else begin
        bg_model[pix_pos] = px;
      end
    end
    last_frame[pix_pos] = px;
    res.back = bg_model[pix_pos];
    if (res.frame_end) begin
      pix_pos = 0;
      primed  = 1'b1;
    end else begin
      pix_pos = pix_pos + 1;
    end
    return res;
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] v, int amp);
    int t;
    t = int'(v) + int'($urandom_range(2 * amp)) - amp;
    if (t < 0) begin
      t = 0;
    end else if (t > 255) begin
      t = 255;
    end
    return t[7:0];
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Queue one pixel and track where it lands in the frame
  task automatic offer_pixel(pix_t px);
    pixels_to_send.push_back(px);
    offered_count++;
    if (gen_pos < SCENE_DEPTH) begin
      scene[gen_pos] = px;
    end
    gen_pos = (gen_pos + 1 >= frame_span()) ? 0 : gen_pos + 1;
  endtask

  // Mostly the previous scene plus noise, some fresh pixels
  task automatic queue_pixels(int count, int amp, int fresh_pct);
    pix_t px;
    pix_t base;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < fresh_pct) begin
        px = 24'($urandom);
      end else begin
        base = scene[gen_pos];
        px   = {jitter(base.red, amp), jitter(base.green, amp), jitter(base.blue, amp)};
      end
      offer_pixel(px);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DIFF_THRESHOLD: thr_now = data[7:0];
      REG_FRAME_PIXELS:   frame_cfg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every expected result is back, then let the pipe settle
  task automatic drain();
    while (result_count < offered_count) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: predict on each accepted transaction, then offer the next pixel
  always @(posedge clk) begin : pixel_driver
    pix_t px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        px = {in_pix_red, in_pix_green, in_pix_blue};
        expected_segments.push_back(segment_pixel(px));
      end
      if (!in_valid || in_ready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          px = pixels_to_send.pop_front();
          in_valid     <= 1'b1;
          in_pix_blue  <= px.blue;
          in_pix_green <= px.green;
          in_pix_red   <= px.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin : result_sink
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_ready <= !hold_req && hold_left == 0 && $urandom_range(99) >= stall_pct;
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_monitor
    seg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (expected_segments.size() == 0) begin
        flag_error("result transaction with nothing expected");
      end else begin
        want = expected_segments.pop_front();
        if (out_fore_blue !== want.fore.blue)
          flag_error($sformatf("fore_blue %0h, want %0h", out_fore_blue, want.fore.blue));
        if (out_fore_green !== want.fore.green)
          flag_error($sformatf("fore_green %0h, want %0h", out_fore_green, want.fore.green));
        if (out_fore_red !== want.fore.red)
          flag_error($sformatf("fore_red %0h, want %0h", out_fore_red, want.fore.red));
        if (out_back_blue !== want.back.blue)
          flag_error($sformatf("back_blue %0h, want %0h", out_back_blue, want.back.blue));
        if (out_back_green !== want.back.green)
          flag_error($sformatf("back_green %0h, want %0h", out_back_green, want.back.green));
        if (out_back_red !== want.back.red)
          flag_error($sformatf("back_red %0h, want %0h", out_back_red, want.back.red));
        if (out_moving !== want.moving)
          flag_error($sformatf("moving %0b, want %0b", out_moving, want.moving));
        if (out_frame_end !== want.frame_end)
          flag_error($sformatf("frame_end %0b, want %0b", out_frame_end, want.frame_end));
      end
    end
  end

  // Cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    for (int p = 0; p < MAX_PIXELS; p++) begin
      last_frame[p] = '0;
      bg_model[p]   = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // First frame at the largest size: only loads the prior store
    write_reg(REG_FRAME_PIXELS, CFG_W'(MAX_PIXELS));
    write_reg(REG_DIFF_THRESHOLD, 18'h3FF00);
    offer_pixel(24'h000000);
    offer_pixel(24'hFFFFFF);
    offer_pixel(24'hFF0000);
    offer_pixel(24'h00FF00);
    offer_pixel(24'h0000FF);
    offer_pixel(24'hAAAAAA);
    offer_pixel(24'h555555);
    queue_pixels(121, 0, 100);
    drain();
    write_reg(REG_FRAME_PIXELS, FRAME_OVERSIZE);
    queue_pixels(128, 0, 100);
    drain();

    // Shrink to zero size mid-frame: next pixel ends the first frame
    write_reg(REG_FRAME_PIXELS, '0);
    offer_pixel(24'hFFFFFF);
    // One-pixel frames at threshold zero: full swing, no change, single-step deltas
    offer_pixel(24'hFFFFFF);
    offer_pixel(24'hFFFFFF);
    offer_pixel(24'hFFFEFF);
    offer_pixel(24'hFFFEFE);
    offer_pixel(24'hFEFEFE);
    offer_pixel(24'h000000);
    drain();
    // A write to a spare index must leave the threshold alone
    write_reg(REG_SPARE_HI, 18'h000FF);
    offer_pixel(24'hFFFFFF);
    drain();
    // Full swing stays static at the top threshold
    write_reg(REG_DIFF_THRESHOLD, 18'h000FF);
    offer_pixel(24'h000000);
    offer_pixel(24'h000000);
    drain();

    // Random phases: new settings, pacing mode and scene noise each time
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_idle_pct = pace_send[ph % 4];
      stall_pct     = pace_stall[ph % 4];
      case ($urandom_range(3))
        0:       write_reg(REG_DIFF_THRESHOLD, '0);
        1:       write_reg(REG_DIFF_THRESHOLD, {10'($urandom), 8'hFF});
        default: write_reg(REG_DIFF_THRESHOLD, CFG_W'($urandom_range(8, 60)));
      endcase
      case ($urandom_range(5))
        0:       write_reg(REG_FRAME_PIXELS, '0);
        1:       write_reg(REG_FRAME_PIXELS, CFG_W'(1));
        2:       write_reg(REG_FRAME_PIXELS, CFG_W'($urandom_range(2, 16)));
        3:       write_reg(REG_FRAME_PIXELS, CFG_W'($urandom_range(17, 64)));
        4:       write_reg(REG_FRAME_PIXELS, CFG_W'($urandom_range(65, PRIMED_SPAN)));
        default: ;
      endcase
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
      end
      if (ph == 4 || ph == 9) begin
        // Full-rate sender against a long receiver hold-off: fill the pipe
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_pixels(90, $urandom_range(4, 60), 10);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        queue_pixels($urandom_range(60, 100), $urandom_range(4, 60), 10);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
